// ----- rtl/nrmc_pkg.sv -----
// Shared types and character constants for the NMEA RMC field splitter.
package nrmc_pkg;

    localparam logic [2:0]  HDR_LEN    = 3'd6;
    localparam logic [7:0]  CHAR_CR    = 8'h0D;
    localparam logic [7:0]  CHAR_LF    = 8'h0A;
    localparam logic [7:0]  CHAR_COMMA = 8'h2C;
    localparam logic [7:0]  CHAR_STAR  = 8'h2A;
    localparam logic [3:0]  FIELD_MAX  = 4'd15;
    localparam logic [47:0] HDR_RESET  = 48'h244750524D43;

    localparam int IN_W  = 9;
    localparam int OUT_W = 17;

    // Result item, packed as it leaves on the master side
    typedef struct packed {
        logic       end_of_sentence;
        logic [7:0] char_value;
        logic [3:0] char_position;
        logic [3:0] field_index;
    } t_result;

    // Input item held in the input register
    typedef struct packed {
        logic       frame_error;
        logic [7:0] rx_byte;
    } t_in_item;

endpackage

// ----- rtl/nrmc_pipe_reg.sv -----
// One-deep pipeline register with valid/ready handshake on both sides.
module nrmc_pipe_reg #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic         r_valid;
    logic [W-1:0] r_data;

    // Refill in the same cycle the held item leaves
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/nrmc_parser.sv -----
// Sentence state and per-character decision: header match, field and position counting.
module nrmc_parser import nrmc_pkg::*; #(
    parameter int MAX_FIELD_CHARS = 16,
    parameter int LAST_FIELD      = 13
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_wdata,
    input  logic        i_valid,
    input  t_in_item    i_item,
    input  logic        i_out_ready,
    output logic        o_emit,
    output t_result     o_result
);

    localparam int POS_W = $clog2(MAX_FIELD_CHARS + 1);

    logic [47:0]      r_header;
    logic [2:0]       r_hdr_cnt;
    logic             r_hdr_mis;
    logic [3:0]       r_field;
    logic [POS_W-1:0] r_pos;

    logic [2:0]       n_hdr_cnt;
    logic             n_hdr_mis;
    logic [3:0]       n_field;
    logic [POS_W-1:0] n_pos;

    logic             fire;
    logic [7:0]       want;
    logic             pos_room;
    logic             field_live;
    logic [POS_W+3:0] pos_ext;
    logic [7:0]       ch;

    assign ch         = i_item.rx_byte;
    assign fire       = i_valid && i_out_ready;
    assign pos_room   = r_pos < POS_W'(MAX_FIELD_CHARS);
    assign field_live = (r_field != 4'd0) && (r_field <= 4'(LAST_FIELD));
    assign pos_ext    = {4'd0, r_pos};

    // Header character expected at this count, first one in the top byte
    always_comb begin
        case (r_hdr_cnt)
            3'd0:    want = r_header[47:40];
            3'd1:    want = r_header[39:32];
            3'd2:    want = r_header[31:24];
            3'd3:    want = r_header[23:16];
            3'd4:    want = r_header[15:8];
            default: want = r_header[7:0];
        endcase
    end

    always_comb begin
        n_hdr_cnt = r_hdr_cnt;
        n_hdr_mis = r_hdr_mis;
        n_field   = r_field;
        n_pos     = r_pos;
        o_emit    = 1'b0;
        o_result  = '0;
        if (i_item.frame_error || ch == CHAR_LF) begin
            // dropped, state holds
        end else if (ch == CHAR_CR) begin
            n_hdr_cnt = '0;
            n_hdr_mis = 1'b0;
            n_field   = '0;
            n_pos     = '0;
            if (r_hdr_cnt >= HDR_LEN && !r_hdr_mis) begin
                o_emit                   = 1'b1;
                o_result.char_value      = CHAR_CR;
                o_result.end_of_sentence = 1'b1;
            end
        end else if (r_hdr_cnt < HDR_LEN) begin
            n_hdr_cnt = r_hdr_cnt + 3'd1;
            if (ch != want) begin
                n_hdr_mis = 1'b1;
            end
        end else if (r_hdr_mis) begin
            // rest of a foreign sentence is ignored
        end else if (ch == CHAR_COMMA || ch == CHAR_STAR) begin
            if (r_field != FIELD_MAX) begin
                n_field = r_field + 4'd1;
            end
            n_pos = '0;
        end else if (pos_room) begin
            n_pos = r_pos + POS_W'(1);
            if (field_live) begin
                o_emit                 = 1'b1;
                o_result.field_index   = r_field;
                o_result.char_position = pos_ext[3:0];
                o_result.char_value    = ch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= HDR_RESET;
            r_hdr_cnt <= '0;
            r_hdr_mis <= 1'b0;
            r_field   <= '0;
            r_pos     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_header <= i_cfg_wdata;
            end
            if (fire) begin
                r_hdr_cnt <= n_hdr_cnt;
                r_hdr_mis <= n_hdr_mis;
                r_field   <= n_field;
                r_pos     <= n_pos;
            end
        end
    end

endmodule

// ----- rtl/nmea_rmc_field_splitter.sv -----
// Top level of the NMEA RMC field splitter.
//
// Slave side takes one received UART byte per item (tdata) with its
// framing-error flag (tuser); flagged bytes and line feeds are dropped.
// The first six characters of each sentence are compared with the header
// register (reset "$GPRMC", written through i_cfg_we / i_cfg_wdata; the
// user writes it only while idle, the block does not enforce this). For
// a matching sentence every character of fields 1 to LAST_FIELD, up to
// MAX_FIELD_CHARS per field, leaves on the master side with its field
// number and position; the closing carriage return gives a last item with
// tlast high. Throughput: one item per cycle while the receiver takes results.
// Each byte is accepted into the input register, and its result is
// registered in the result register after one level of compare and
// count logic. Reset clears both registers' valid flags and the
// sentence state and restores the default header. When the receiver
// stalls, the result register holds its item; one further byte sits in
// the input register and s_axis_tready drops until the result is taken.
module nmea_rmc_field_splitter import nrmc_pkg::*; #(
    parameter int MAX_FIELD_CHARS = 16,
    parameter int LAST_FIELD      = 13
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] frame_error
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] field_index, [7:4] char_position,
                                        // [15:8] char_value
    output logic        m_axis_tlast    // end_of_sentence
);

    t_in_item in_item;
    logic     in_valid;
    logic     out_ready;
    logic     emit;
    t_result  result;
    t_result  out_result;

    nrmc_pipe_reg #(
        .W (IN_W)
    ) u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  ({s_axis_tuser, s_axis_tdata}),
        .o_valid (in_valid),
        .i_ready (out_ready),
        .o_data  (in_item)
    );

    nrmc_parser #(
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS),
        .LAST_FIELD      (LAST_FIELD)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (in_valid),
        .i_item      (in_item),
        .i_out_ready (out_ready),
        .o_emit      (emit),
        .o_result    (result)
    );

    nrmc_pipe_reg #(
        .W (OUT_W)
    ) u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid && emit),
        .o_ready (out_ready),
        .i_data  (result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_result)
    );

    assign m_axis_tdata = {out_result.char_value, out_result.char_position,
                           out_result.field_index};
    assign m_axis_tlast = out_result.end_of_sentence;

endmodule

// ----- rtl/nrmc_checker.sv -----
// Port-level checks for the NMEA RMC field splitter, bound to the top level.
module nrmc_checker #(
    parameter int LAST_FIELD = 13
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // Sentence-end item carries field 0, position 0 and the carriage return
    a_eos_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tdata == 16'h0D00))
        else $error("sentence-end item malformed");

    // Character items lie in fields 1 to LAST_FIELD
    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
            (m_axis_tdata[3:0] != 4'd0 && m_axis_tdata[3:0] <= 4'(LAST_FIELD)))
        else $error("field number out of range");

    // Stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled item changed");

    // Nothing on the master side straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");

    // An empty result register never blocks the slave side
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind nmea_rmc_field_splitter nrmc_checker #(
    .LAST_FIELD (LAST_FIELD)
) u_nrmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
